/* rtl/sus_pkg.sv */
// sus_pkg: shared types and codes for the sorted unique set
// used by sus_cell and sorted_unique_set; no dependencies

package sus_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // operation kinds of an input item
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LIST   = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ELEMENT  = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  // per-cycle operation broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    data_t    value;
  } cell_ctl_t;

endpackage

/* rtl/sus_cell.sv */
// sus_cell: one slot of the sorted chain, holds an entry and its valid bit
// depends on sus_pkg

module sus_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  sus_pkg::cell_ctl_t ctl,
  input  logic             left_valid,
  input  logic             left_lt,
  input  sus_pkg::data_t   left_entry,
  input  logic             right_valid,
  input  sus_pkg::data_t   right_entry,
  input  sus_pkg::data_t   wrap_entry,
  output logic             valid,
  output logic             lt,
  output logic             eq,
  output sus_pkg::data_t   entry
);
  import sus_pkg::*;

  data_t entry_r, entry_nxt;
  logic  valid_r, valid_nxt;

  assign valid = valid_r;
  assign entry = entry_r;
  assign lt    = valid_r && (entry_r < ctl.value);
  assign eq    = valid_r && (entry_r == ctl.value);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (!lt) begin
          entry_nxt = left_lt ? ctl.value : left_entry;
          valid_nxt = left_valid;
        end
      end
      CELL_DELETE: begin
        if (!lt) begin
          entry_nxt = right_entry;
          valid_nxt = right_valid;
        end
      end
      CELL_ROTATE: begin
        // last valid slot picks up the head so the ring closes
        entry_nxt = (valid_r && !right_valid) ? wrap_entry : right_entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* rtl/sorted_unique_set.sv */
// sorted_unique_set: insert, delete and an empty list give exactly one result, in the cycle
// after accept; insert and delete sustain one item per cycle while the receiver does not stall;
// a list of n entries enters the list state, then loads its elements into the output register
// one per cycle while the receiver does not stall, the chain rotating one slot per element;
// the input stalls while a list streams or while the receiver stalls
// synchronous reset clears the valid bits, state, both counts and output valid; no entry reset

module sorted_unique_set #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic signed [31:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic signed [31:0]   out_element,
  output logic                 out_last
);
  import sus_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  // list sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_LIST = 2'b10
  } fsm_t;

  fsm_t             state_r, state_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [OCC_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  data_t            out_element_r, out_element_nxt;
  logic             out_last_r, out_last_nxt;

  cell_ctl_t        ctl;
  logic [CAPACITY-1:0] valid_vec, lt_vec, eq_vec;
  data_t            entry_arr [CAPACITY];

  logic             can_load;
  logic             in_fire;
  logic             found;
  logic             full;

  // output register is free when empty or being taken this cycle
  assign can_load  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != FSM_IDLE) || !can_load;
  assign in_fire   = in_valid && !in_stall;

  assign found = |eq_vec;
  assign full  = valid_vec[CAPACITY-1];

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  // cell chain: entry 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  l_valid, l_lt, r_valid;
    data_t l_entry, r_entry;

    if (i == 0) begin : g_head
      assign l_valid = 1'b1;
      assign l_lt    = 1'b1;
      assign l_entry = ctl.value;
    end else begin : g_body
      assign l_valid = valid_vec[i-1];
      assign l_lt    = lt_vec[i-1];
      assign l_entry = entry_arr[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_entry = entry_arr[i];
    end else begin : g_inner
      assign r_valid = valid_vec[i+1];
      assign r_entry = entry_arr[i+1];
    end

    sus_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_valid (l_valid),
      .left_lt    (l_lt),
      .left_entry (l_entry),
      .right_valid(r_valid),
      .right_entry(r_entry),
      .wrap_entry (entry_arr[0]),
      .valid      (valid_vec[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i]),
      .entry      (entry_arr[i])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    occ_nxt         = occ_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    ctl.op          = CELL_HOLD;
    ctl.value       = in_value;

    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_INSERT: begin
              out_valid_nxt   = 1'b1;
              out_element_nxt = in_value;
              out_last_nxt    = 1'b1;
              if (found) begin
                out_status_nxt = ST_PRESENT;
              end else if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_INSERTED;
                ctl.op         = CELL_INSERT;
                occ_nxt        = occ_r + OCC_W'(1);
              end
            end
            KIND_DELETE: begin
              out_valid_nxt   = 1'b1;
              out_element_nxt = in_value;
              out_last_nxt    = 1'b1;
              if (found) begin
                out_status_nxt = ST_REMOVED;
                ctl.op         = CELL_DELETE;
                occ_nxt        = occ_r - OCC_W'(1);
              end else begin
                out_status_nxt = ST_NOTFOUND;
              end
            end
            KIND_LIST: begin
              if (!valid_vec[0]) begin
                out_valid_nxt   = 1'b1;
                out_status_nxt  = ST_EMPTY;
                out_element_nxt = '0;
                out_last_nxt    = 1'b1;
              end else begin
                state_nxt = FSM_LIST;
                cnt_nxt   = occ_r;
              end
            end
            default: begin
              // unused kind: no result
            end
          endcase
        end
      end
      FSM_LIST: begin
        // send the head, rotate the ring by one slot
        if (can_load) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_ELEMENT;
          out_element_nxt = entry_arr[0];
          out_last_nxt    = (cnt_r == OCC_W'(1));
          ctl.op          = CELL_ROTATE;
          cnt_nxt         = cnt_r - OCC_W'(1);
          if (cnt_r == OCC_W'(1)) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // occupied slots always form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("valid bits not a prefix");

  // occupancy count tracks the valid bits
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_vec) == int'(occ_r)))
    else $error("occupancy count mismatch");

  // no new item is taken while a list is streaming
  a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_LIST) |-> in_stall)
    else $error("input accepted during list");

  // sending the final listed element ends the list
  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == FSM_LIST) && can_load && (cnt_r == OCC_W'(1)))
      |=> (state_r == FSM_IDLE) && out_valid && out_last)
    else $error("list did not end on last element");

  // an accepted insert of a value already stored never changes occupancy
  a_dup_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_kind == KIND_INSERT) && found) |=> $stable(occ_r))
    else $error("duplicate insert changed occupancy");
`endif

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for sorted_unique_set, a sorted table of distinct signed words
// depends on sus_pkg and sorted_unique_set under rtl; keeps its own copy of the set
// and checks every reply against it under random gaps and stalls on both channels

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sus_pkg::*;

  localparam int CAP = 16;
  localparam int HOLD_CYCLES = 200;    // long receiver hold-off, stalls the input
  localparam int SETTLE_CYCLES = 20;   // quiet time after the last reply
  localparam int IDLE_LIMIT = 2000;    // cycles with no accepted item on either side
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // one reply of the block
  typedef struct {
    status_t    status;
    data_t      element;
    logic       last;
  } set_reply_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  logic [1:0]   in_kind;
  data_t        in_value;
  logic         out_valid;
  logic         out_stall;
  logic [2:0]   out_status;
  data_t        out_element;
  logic         out_last;

  // own copy of the set, updated once per accepted item
  data_t        set_tbl [CAP];
  int           set_count;
  set_reply_t   replies_due [$];
  set_reply_t   reply_head;

  int           mismatch_count = 0;
  bit           no_idle = 1'b0;     // both sides run without gaps
  bit           hold_req = 1'b0;    // asks the receiver for one long hold-off

  sorted_unique_set #(
    .CAPACITY(CAP)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_element(out_element),
    .out_last   (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one item to the set copy and queues the replies it causes
  function automatic void apply_set_op(input logic [1:0] kind, input data_t value);
    int pos;
    set_reply_t rep;
    pos = 0;
    case (kind)
      KIND_LIST: begin
        if (set_count == 0) begin
          rep = '{status: ST_EMPTY, element: '0, last: 1'b1};
          replies_due.push_back(rep);
        end else begin
          for (int j = 0; j < set_count; j++) begin
            rep = '{status: ST_ELEMENT, element: set_tbl[j], last: (j == set_count - 1)};
            replies_due.push_back(rep);
          end
        end
      end
      KIND_INSERT, KIND_DELETE: begin
        // first slot not below the value, signed order
        while (pos < set_count && set_tbl[pos] < value) pos++;
        rep = '{status: ST_INSERTED, element: value, last: 1'b1};
        if (kind == KIND_INSERT) begin
          // duplicate wins over full
          if (pos < set_count && set_tbl[pos] == value) begin
            rep.status = ST_PRESENT;
          end else if (set_count >= CAP) begin
            rep.status = ST_FULL;
          end else begin
            for (int j = set_count; j > pos; j--) set_tbl[j] = set_tbl[j-1];
            set_tbl[pos] = value;
            set_count++;
          end
        end else begin
          if (pos < set_count && set_tbl[pos] == value) begin
            for (int j = pos; j + 1 < set_count; j++) set_tbl[j] = set_tbl[j+1];
            set_count--;
            rep.status = ST_REMOVED;
          end else begin
            rep.status = ST_NOTFOUND;
          end
        end
        replies_due.push_back(rep);
      end
      default: ;  // unused kind: no reply, set unchanged
    endcase
  endfunction

  // random value: small range near zero, full range, or near the extremes
  function automatic data_t pick_value();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 40) - 20;
      1: return $urandom;
      default: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_fff0)
                      + $urandom_range(0, 15);
    endcase
  endfunction

  // offers one item after a random gap and waits until it is taken
  // valid stays high on return so a back-to-back item needs no second assignment
  task automatic send_item(input logic [1:0] kind, input data_t value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    apply_set_op(kind, value);
  endtask

  // sender pause: drop valid and wait until every reply has come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  // every operation, the value extremes and the head, middle, tail and empty corners of the set
  task automatic test_directed();
    send_item(KIND_LIST,   32'sd0);            // list of an empty set
    send_item(KIND_DELETE, 32'sd7);            // delete from an empty set
    send_item(KIND_INSERT, 32'sd0);
    send_item(KIND_INSERT, 32'sh7fff_ffff);    // most positive
    send_item(KIND_INSERT, 32'sh8000_0000);    // most negative
    send_item(KIND_INSERT, -32'sd1);
    send_item(KIND_INSERT, 32'sd1);
    send_item(KIND_INSERT, 32'sd0);            // duplicate in the middle
    send_item(KIND_INSERT, 32'sh8000_0000);    // duplicate at the head
    send_item(KIND_UNUSED, 32'shffff_ffff);    // ignored item
    send_item(KIND_LIST,   32'sh1234_5678);    // value ignored on list
    send_item(KIND_DELETE, 32'sd5);            // absent value
    send_item(KIND_DELETE, 32'sh8000_0000);    // head entry
    send_item(KIND_DELETE, 32'sh7fff_ffff);    // tail entry
    send_item(KIND_DELETE, 32'sd0);            // middle entry
    send_item(KIND_INSERT, 32'sh5555_5555);
    send_item(KIND_INSERT, 32'shaaaa_aaaa);
    send_item(KIND_LIST,   32'sd0);
    send_item(KIND_DELETE, -32'sd1);
    send_item(KIND_DELETE, 32'sd1);
    send_item(KIND_DELETE, 32'sh5555_5555);
    send_item(KIND_DELETE, 32'shaaaa_aaaa);    // last entry, set empty again
    send_item(KIND_LIST,   32'sd0);
    send_item(KIND_DELETE, 32'shaaaa_aaaa);    // already gone
  endtask

  // fill the table, then hit it while full and list all slots
  task automatic test_fill_to_capacity();
    while (set_count < CAP) send_item(KIND_INSERT, pick_value());
    send_item(KIND_INSERT, set_tbl[CAP/2] + 32'sd1 == set_tbl[CAP/2+1] ?
              set_tbl[0] - 32'sd1 : set_tbl[CAP/2] + 32'sd1);  // new value, full table
    send_item(KIND_INSERT, set_tbl[CAP-1]);    // duplicate while full
    send_item(KIND_LIST,   32'sd0);            // longest list
    send_item(KIND_DELETE, set_tbl[3]);
    send_item(KIND_INSERT, pick_value());      // one slot free again
  endtask

  // mixed traffic, partly on values that are in the set
  task automatic test_random_mix(input int n_items);
    int done;
    int r;
    logic [1:0] kind;
    data_t value;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 4) kind = KIND_UNUSED;
      else if (r < 14) kind = KIND_LIST;
      else if (r < (set_count > CAP * 3 / 4 ? 45 : 70)) kind = KIND_INSERT;
      else kind = KIND_DELETE;
      // deletes mostly hit stored values, some inserts are duplicates
      if (set_count > 0 &&
          ((kind == KIND_DELETE && $urandom_range(0, 3) != 0) ||
           (kind == KIND_INSERT && $urandom_range(0, 3) == 0)))
        value = set_tbl[$urandom_range(0, set_count - 1)];
      else
        value = pick_value();
      send_item(kind, value);
      if (kind != KIND_UNUSED) done++;
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_output_hold();
    hold_req = 1'b1;
    test_random_mix(12);
  endtask

  // back-to-back items and no stalls on either side
  task automatic test_no_idle();
    no_idle = 1'b1;
    test_random_mix(25);
    drain_replies();
    no_idle = 1'b0;
  endtask

  // receiver: random stall before each reply, one long hold-off on request
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 10);
      if (hold_req) begin
        wait_cycles = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic report_mismatch(input string field, input longint expv, input longint actv);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expv, actv);
  endtask

  // checks each accepted reply against the oldest one due
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: reply with nothing due, status %0d element %0d last %0b",
                 $time, out_status, out_element, out_last);
      end else begin
        reply_head = replies_due.pop_front();
        if (out_status !== reply_head.status)
          report_mismatch("status", reply_head.status, out_status);
        if (out_element !== reply_head.element)
          report_mismatch("element", reply_head.element, out_element);
        if (out_last !== reply_head.last)
          report_mismatch("last", reply_head.last, out_last);
      end
    end
  end

  // watchdog: ends the run after too many cycles without any accepted item or reply
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = KIND_INSERT;
    in_value  = '0;
    set_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    drain_replies();
    test_fill_to_capacity();
    drain_replies();
    test_random_mix(90);
    drain_replies();
    test_output_hold();
    drain_replies();
    test_no_idle();

    // let any stray reply show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (replies_due.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d replies never arrived", $time, replies_due.size());
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sus_pkg.sv
rtl/sus_cell.sv
rtl/sorted_unique_set.sv
dv/tb.sv
